[hw/rtl/adfp_pkg.sv]
// Shared types, frame constants and the character-to-digit decode for the
// ASCII distance frame parser. No dependencies.
package adfp_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 5;
    localparam int DIST_W = 16;
    localparam int DIGIT_W = 6;

    localparam logic [BYTE_W-1:0] HEADER_CHAR = 8'h7E;
    localparam logic [BYTE_W-1:0] CR_CHAR     = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_CHAR     = 8'h0A;
    localparam logic [BYTE_W-1:0] ZERO_CHAR   = 8'h30;
    localparam logic [BYTE_W-1:0] NINE_CHAR   = 8'h39;
    localparam logic [BYTE_W-1:0] A_CHAR      = 8'h41;
    localparam logic [BYTE_W-1:0] Z_CHAR      = 8'h5A;

    localparam int PAYLOAD_LEN     = 16;
    localparam int FIRST_DIGIT_POS = 9;

    localparam logic [POS_W-1:0] POS_IDLE  = 5'd0;
    localparam logic [POS_W-1:0] POS_FIRST = 5'd1;
    localparam logic [POS_W-1:0] POS_LAST  = 5'(PAYLOAD_LEN);
    localparam logic [POS_W-1:0] POS_CR    = 5'(PAYLOAD_LEN + 1);
    localparam logic [POS_W-1:0] POS_LF    = 5'(PAYLOAD_LEN + 2);

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } digit_t;

    typedef struct packed {
        logic              emit;
        logic [DIST_W-1:0] distance;
    } result_t;

    function automatic digit_t decode_digit(input logic [BYTE_W-1:0] c);
        digit_t d;
        logic [BYTE_W-1:0] diff;
        d    = '0;
        diff = '0;
        if (c inside {[ZERO_CHAR:NINE_CHAR]}) begin
            diff  = c - ZERO_CHAR;
            d.ok  = 1'b1;
            d.val = diff[DIGIT_W-1:0];
        end else if (c inside {[A_CHAR:Z_CHAR]}) begin
            diff  = c - A_CHAR + 8'd10;
            d.ok  = 1'b1;
            d.val = diff[DIGIT_W-1:0];
        end
        return d;
    endfunction

endpackage

[hw/rtl/ascii_distance_frame_parser_unit.sv]
// ASCII distance frame parser: takes one received byte per item and accepts
// a new byte every clock cycle unless a result waits unaccepted. A byte is
// registered on entry and parsed when the parser steps; a frame closed by LF
// loads its distance into the output register as its LF is parsed. The output
// and input registers stall together only while a result waits unaccepted.
// Frames are '~', 16 payload bytes (digits read at positions 9 onward,
// DIGIT_COUNT of them), CR, LF; a wrong trailer byte drops the frame.
// Depends on adfp_pkg, adfp_in_stage, adfp_parser, adfp_out_stage.
module ascii_distance_frame_parser_unit #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [adfp_pkg::BYTE_W-1:0] rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [adfp_pkg::DIST_W-1:0] distance
);
    import adfp_pkg::*;

    logic              step;
    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    result_t           result;

    adfp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .step       (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    adfp_parser #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_char (held_byte),
        .result  (result)
    );

    adfp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .result     (result),
        .step       (step),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .distance   (distance)
    );

endmodule

[hw/rtl/adfp_in_stage.sv]
// Input register for received bytes: holds one item until the parser steps.
// Depends on adfp_pkg.
module adfp_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [adfp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        step,
    output logic                        held_valid,
    output logic [adfp_pkg::BYTE_W-1:0] held_byte
);
    import adfp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign in_ready   = !valid_reg || step;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

[hw/rtl/adfp_parser.sv]
// Frame position tracker, digit accumulator and result decision.
// Depends on adfp_pkg.
module adfp_parser #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [adfp_pkg::BYTE_W-1:0] rx_char,
    output adfp_pkg::result_t           result
);
    import adfp_pkg::*;

    localparam logic [POS_W-1:0] DIGIT_FIRST = 5'(FIRST_DIGIT_POS);
    localparam logic [POS_W-1:0] DIGIT_LAST  = 5'(FIRST_DIGIT_POS + DIGIT_COUNT - 1);

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [DIST_W-1:0] accum_reg;
    logic [DIST_W-1:0] accum_next;
    digit_t            dig;

    assign dig = decode_digit(rx_char);

    always_comb
    begin
        pos_next        = POS_IDLE;
        accum_next      = accum_reg;
        result.emit     = 1'b0;
        result.distance = accum_reg;
        if (pos_reg == POS_IDLE)
        begin
            if (rx_char == HEADER_CHAR)
            begin
                accum_next = '0;
                pos_next   = POS_FIRST;
            end
        end
        else if (pos_reg <= POS_LAST)
        begin
            if (pos_reg >= DIGIT_FIRST && pos_reg <= DIGIT_LAST && dig.ok)
            begin
                accum_next = {accum_reg[DIST_W-5:0], 4'b0000}
                           + {{(DIST_W-DIGIT_W){1'b0}}, dig.val};
            end
            pos_next = pos_reg + 5'd1;
        end
        else if (pos_reg == POS_CR)
        begin
            pos_next = (rx_char == CR_CHAR) ? POS_LF : POS_IDLE;
        end
        else if (pos_reg == POS_LF)
        begin
            result.emit = (rx_char == LF_CHAR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_IDLE;
            accum_reg <= '0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            accum_reg <= accum_next;
        end
    end

endmodule

[hw/rtl/adfp_out_stage.sv]
// Result register: holds a finished distance until the consumer takes it.
// Depends on adfp_pkg.
module adfp_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        held_valid,
    input  adfp_pkg::result_t           result,
    output logic                        step,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [adfp_pkg::DIST_W-1:0] distance
);
    import adfp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [DIST_W-1:0] dist_reg;

    assign step       = held_valid && (!valid_reg || out_ready);
    assign valid_next = step ? result.emit : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.emit)
        begin
            dist_reg <= result.distance;
        end
    end

    assign out_valid = valid_reg;
    assign distance  = dist_reg;

endmodule

[dv/ascii_distance_frame_parser_unit_tb.sv]
// Testbench for ascii_distance_frame_parser_unit: drives byte items with random gaps,
// predicts each frame's distance in step and checks every result in order.
// Depends on adfp_pkg and the parser RTL.
module ascii_distance_frame_parser_unit_tb;
    import adfp_pkg::*;

    localparam int DIGIT_COUNT  = 4;
    localparam int ITEM_TARGET  = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int WATCHDOG_MAX = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {TRAILER_OK, TRAILER_BAD_CR, TRAILER_BAD_LF} trailer_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              out_valid;
    logic              out_ready;
    logic [DIST_W-1:0] distance;

    logic [POS_W-1:0]  parse_pos   = POS_IDLE;
    logic [DIST_W-1:0] parse_accum = '0;
    logic [DIST_W-1:0] pending_distances[$];

    int  items_sent     = 0;
    int  mismatch_count = 0;
    int  stalled_cycles = 0;
    bit  no_idle        = 1'b0;
    bit  hold_req       = 1'b0;

    ascii_distance_frame_parser_unit #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .distance (distance)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Frame tracker: advances on each accepted byte, queues the distance on LF.
    task automatic track_byte(input logic [BYTE_W-1:0] c);
        logic             is_digit;
        logic [DIGIT_W-1:0] val;
        is_digit = 1'b0;
        val      = '0;
        if (parse_pos == POS_IDLE)
        begin
            if (c == HEADER_CHAR)
            begin
                parse_accum = '0;
                parse_pos   = POS_FIRST;
            end
        end
        else if (parse_pos <= POS_LAST)
        begin
            if (parse_pos >= FIRST_DIGIT_POS && parse_pos < FIRST_DIGIT_POS + DIGIT_COUNT)
            begin
                if (c >= ZERO_CHAR && c <= NINE_CHAR)
                begin
                    is_digit = 1'b1;
                    val      = DIGIT_W'(c - ZERO_CHAR);
                end
                else if (c >= A_CHAR && c <= Z_CHAR)
                begin
                    is_digit = 1'b1;
                    val      = DIGIT_W'(c - A_CHAR + 10);
                end
            end
            if (is_digit)
                parse_accum = DIST_W'({parse_accum, 4'b0000} + val);
            parse_pos = parse_pos + 1'b1;
        end
        else if (parse_pos == POS_CR)
        begin
            parse_pos = (c == CR_CHAR) ? POS_LF : POS_IDLE;
        end
        else if (parse_pos == POS_LF)
        begin
            if (c == LF_CHAR)
                pending_distances.push_back(parse_accum);
            parse_pos = POS_IDLE;
        end
        else
        begin
            parse_pos = POS_IDLE;
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        track_byte(b);
        items_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_digit();
        int r;
        r = $urandom_range(0, 35);
        return (r < 10) ? BYTE_W'(ZERO_CHAR + r) : BYTE_W'(A_CHAR + r - 10);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_other(input logic [BYTE_W-1:0] avoid);
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(0, 255)); while (b == avoid);
        return b;
    endfunction

    // fixed: payload carries a header, 0x00, 0xFF and out-of-window digits around
    // the four given digit bytes; otherwise payload is random.
    task automatic send_frame(input trailer_t trailer, input bit fixed,
                              input logic [31:0] digits);
        logic [BYTE_W-1:0] b;
        int i;
        send_byte(HEADER_CHAR);
        for (i = 1; i <= PAYLOAD_LEN; i++)
        begin
            if (fixed)
            begin
                case (i)
                    1:       b = HEADER_CHAR;
                    2:       b = 8'h00;
                    3:       b = 8'hFF;
                    9:       b = digits[31:24];
                    10:      b = digits[23:16];
                    11:      b = digits[15:8];
                    12:      b = digits[7:0];
                    default: b = (i % 2 == 0) ? A_CHAR : NINE_CHAR;
                endcase
            end
            else if (i >= FIRST_DIGIT_POS && i < FIRST_DIGIT_POS + DIGIT_COUNT &&
                     $urandom_range(0, 7) != 0)
                b = pick_digit();
            else
                b = BYTE_W'($urandom_range(0, 255));
            send_byte(b);
        end
        case (trailer)
            TRAILER_BAD_CR:
            begin
                send_byte($urandom_range(0, 1) ? HEADER_CHAR : pick_other(CR_CHAR));
            end
            TRAILER_BAD_LF:
            begin
                send_byte(CR_CHAR);
                send_byte($urandom_range(0, 1) ? CR_CHAR : pick_other(LF_CHAR));
            end
            default:
            begin
                send_byte(CR_CHAR);
                send_byte(LF_CHAR);
            end
        endcase
    endtask

    task automatic test_idle_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CR_CHAR);
        send_byte(LF_CHAR);
    endtask

    task automatic test_digit_decode();
        send_frame(TRAILER_OK, 1'b1, {Z_CHAR, Z_CHAR, Z_CHAR, Z_CHAR});
        send_frame(TRAILER_OK, 1'b1, {"F", "F", "F", "F"});
        send_frame(TRAILER_OK, 1'b1, {ZERO_CHAR, ZERO_CHAR, ZERO_CHAR, ZERO_CHAR});
        send_frame(TRAILER_OK, 1'b1, {NINE_CHAR, ":", A_CHAR, "@"});
        send_frame(TRAILER_OK, 1'b1, {"/", ZERO_CHAR, "[", Z_CHAR});
    endtask

    task automatic test_trailer_faults();
        send_frame(TRAILER_BAD_CR, 1'b1, {"1", "2", "3", "4"});
        send_byte("5");
        send_frame(TRAILER_BAD_LF, 1'b1, {"5", "6", "7", "8"});
        send_frame(TRAILER_OK, 1'b0, '0);
    endtask

    task automatic test_back_to_back();
        int i;
        no_idle = 1'b1;
        for (i = 0; i < 4; i++)
            send_frame(TRAILER_OK, 1'b0, '0);
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        int i;
        hold_req = 1'b1;
        for (i = 0; i < 4; i++)
            send_frame(TRAILER_OK, 1'b0, '0);
    endtask

    task automatic test_random_traffic();
        int r;
        int i;
        int n;
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                send_byte(BYTE_W'($urandom_range(0, 255)));
            else if (r == 1)
            begin
                send_byte(HEADER_CHAR);
                n = $urandom_range(1, 18);
                for (i = 0; i < n; i++)
                    send_byte(BYTE_W'($urandom_range(0, 255)));
            end
            else if (r == 2)
                send_frame($urandom_range(0, 1) ? TRAILER_BAD_CR : TRAILER_BAD_LF, 1'b0, '0);
            else
            begin
                no_idle = (r == 3);
                send_frame(TRAILER_OK, 1'b0, '0);
                no_idle = 1'b0;
            end
        end
    endtask

    // Result receiver: random ready gaps, plus one long hold-off on request.
    initial
    begin
        int gap;
        bit leave;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            leave = 1'b0;
            while (!leave)
            begin
                @(negedge clk);
                if (out_valid || hold_req)
                    leave = 1'b1;
            end
            @(posedge clk);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && out_valid && out_ready)
        begin
            if (pending_distances.size() == 0)
            begin
                $display("%0t: unexpected distance, expected none, actual %0d",
                         $time, distance);
                mismatch_count++;
            end
            else if (pending_distances[0] !== distance)
            begin
                $display("%0t: distance mismatch, expected %0d, actual %0d",
                         $time, pending_distances[0], distance);
                mismatch_count++;
                void'(pending_distances.pop_front());
            end
            else
                void'(pending_distances.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_MAX)
            begin
                $display("%0t: no handshake for %0d cycles", $time, stalled_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_noise();
        test_digit_decode();
        test_trailer_faults();
        test_back_to_back();
        test_output_stall();
        test_random_traffic();

        in_valid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
